### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SPQ_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("spq assertion failed");

// next-cycle implication, off during reset
`define SPQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("spq assertion failed");

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants and types of the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam int IN_WEIGHT_W = 32;
  localparam int SYMBOL_W    = 8;
  localparam int HANDLE_W    = 9;
  localparam int OCC_W       = 9;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  // per-cycle command broadcast along the row of cells
  typedef struct packed {
    logic ins;
    logic shift;
  } spq_ctrl_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares the broadcast key with its own entry
// and keeps, takes the new entry, or takes a neighbour's entry
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int WEIGHT_BITS = spq_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire spq_pkg::spq_ctrl_t        ctrl,
  input  wire logic                      occ,
  input  wire logic [WEIGHT_BITS-1:0]    key_weight,
  input  wire logic [spq_pkg::SYMBOL_W-1:0] key_symbol,
  input  wire logic [spq_pkg::HANDLE_W-1:0] key_handle,
  input  wire logic                      left_lt,
  input  wire logic [WEIGHT_BITS-1:0]    left_weight,
  input  wire logic [spq_pkg::SYMBOL_W-1:0] left_symbol,
  input  wire logic [spq_pkg::HANDLE_W-1:0] left_handle,
  input  wire logic [WEIGHT_BITS-1:0]    right_weight,
  input  wire logic [spq_pkg::SYMBOL_W-1:0] right_symbol,
  input  wire logic [spq_pkg::HANDLE_W-1:0] right_handle,
  output logic                           lt,
  output logic [WEIGHT_BITS-1:0]         weight,
  output logic [spq_pkg::SYMBOL_W-1:0]   symbol,
  output logic [spq_pkg::HANDLE_W-1:0]   handle
);
  import spq_pkg::*;

  logic [WEIGHT_BITS-1:0] weight_next;
  logic [SYMBOL_W-1:0]    symbol_next;
  logic [HANDLE_W-1:0]    handle_next;

  // new key orders strictly before this slot, or the slot is free
  always_comb begin
    lt = !occ || (key_weight < weight) ||
         ((key_weight == weight) && (key_symbol < symbol));
  end

  always_comb begin
    weight_next = weight;
    symbol_next = symbol;
    handle_next = handle;
    if (ctrl.ins) begin
      if (lt && !left_lt) begin
        weight_next = key_weight;
        symbol_next = key_symbol;
        handle_next = key_handle;
      end else if (lt) begin
        weight_next = left_weight;
        symbol_next = left_symbol;
        handle_next = left_handle;
      end
    end else if (ctrl.shift) begin
      weight_next = right_weight;
      symbol_next = right_symbol;
      handle_next = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    weight <= weight_next;
    symbol <= symbol_next;
    handle <= handle_next;
  end

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// min-priority queue kept sorted in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries kind plus the entry to enqueue;
// output channel (out_valid/out_ready) carries one result word per item.
// Ordering is by weight, then symbol; equal keys leave first in, first out.
// Every cell compares the broadcast key with its own entry in the same cycle,
// so the time an enqueue or a dequeue takes does not depend on the occupancy.
// The result word is registered and is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes every word.
// A result word sits in the output register; in_ready stays high while that
// register is empty or being taken in the same cycle, so a stalled receiver
// holds off the input for as long as a word waits.
// A full-queue enqueue and an empty-queue dequeue return ok low with zeros.
// Reset clears the entry count and the output valid flag; cell contents are
// left as they are and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
  parameter int WEIGHT_BITS = spq_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             kind,
  input  wire logic [spq_pkg::IN_WEIGHT_W-1:0]  in_weight,
  input  wire logic [spq_pkg::SYMBOL_W-1:0]     in_symbol,
  input  wire logic [spq_pkg::HANDLE_W-1:0]     in_handle,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  ok,
  output logic [spq_pkg::IN_WEIGHT_W-1:0]       out_weight,
  output logic [spq_pkg::SYMBOL_W-1:0]          out_symbol,
  output logic [spq_pkg::HANDLE_W-1:0]          out_handle,
  output logic                                  is_empty,
  output logic                                  is_single,
  output logic [spq_pkg::OCC_W-1:0]             occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                   accept;
  logic                   enq_do;
  logic                   deq_do;
  spq_ctrl_t              ctrl;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [WEIGHT_BITS-1:0] key_weight;
  logic [WEIGHT_BITS+IN_WEIGHT_W-1:0] key_ext;
  logic [WEIGHT_BITS+IN_WEIGHT_W-1:0] head_ext;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  logic [CAPACITY-1:0]    lt;
  logic [CAPACITY-1:0]    occ;
  logic [WEIGHT_BITS-1:0] cell_weight [CAPACITY];
  logic [SYMBOL_W-1:0]    cell_symbol [CAPACITY];
  logic [HANDLE_W-1:0]    cell_handle [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign enq_do   = accept && (kind == KIND_ENQ) && (count < CNT_W'(CAPACITY));
  assign deq_do   = accept && (kind == KIND_DEQ) && (count != '0);

  assign key_ext    = {{WEIGHT_BITS{1'b0}}, in_weight};
  assign key_weight = key_ext[WEIGHT_BITS-1:0];
  assign head_ext   = {{IN_WEIGHT_W{1'b0}}, cell_weight[0]};

  always_comb begin
    ctrl.ins   = enq_do;
    ctrl.shift = deq_do;
    count_next = count;
    if (enq_do) begin
      count_next = count + CNT_W'(1);
    end else if (deq_do) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                   left_lt;
      logic [WEIGHT_BITS-1:0] left_weight;
      logic [SYMBOL_W-1:0]    left_symbol;
      logic [HANDLE_W-1:0]    left_handle;
      logic [WEIGHT_BITS-1:0] right_weight;
      logic [SYMBOL_W-1:0]    right_symbol;
      logic [HANDLE_W-1:0]    right_handle;

      assign occ[gi] = count > CNT_W'(gi);

      if (gi == 0) begin : g_first
        assign left_lt     = 1'b0;
        assign left_weight = key_weight;
        assign left_symbol = in_symbol;
        assign left_handle = in_handle;
      end else begin : g_mid
        assign left_lt     = lt[gi-1];
        assign left_weight = cell_weight[gi-1];
        assign left_symbol = cell_symbol[gi-1];
        assign left_handle = cell_handle[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_weight = key_weight;
        assign right_symbol = in_symbol;
        assign right_handle = in_handle;
      end else begin : g_inner
        assign right_weight = cell_weight[gi+1];
        assign right_symbol = cell_symbol[gi+1];
        assign right_handle = cell_handle[gi+1];
      end

      spq_cell #(
        .WEIGHT_BITS (WEIGHT_BITS)
      ) u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .occ          (occ[gi]),
        .key_weight   (key_weight),
        .key_symbol   (in_symbol),
        .key_handle   (in_handle),
        .left_lt      (left_lt),
        .left_weight  (left_weight),
        .left_symbol  (left_symbol),
        .left_handle  (left_handle),
        .right_weight (right_weight),
        .right_symbol (right_symbol),
        .right_handle (right_handle),
        .lt           (lt[gi]),
        .weight       (cell_weight[gi]),
        .symbol       (cell_symbol[gi]),
        .handle       (cell_handle[gi])
      );
    end
  endgenerate

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok         <= enq_do || deq_do;
      out_weight <= deq_do ? head_ext[IN_WEIGHT_W-1:0] : '0;
      out_symbol <= deq_do ? cell_symbol[0] : '0;
      out_handle <= deq_do ? cell_handle[0] : '0;
      is_empty   <= (count_next == '0);
      is_single  <= (count_next == CNT_W'(1));
      occupancy  <= cnt_ext[OCC_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the sorted priority queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             kind,
  input wire logic [spq_pkg::IN_WEIGHT_W-1:0]  in_weight,
  input wire logic [spq_pkg::SYMBOL_W-1:0]     in_symbol,
  input wire logic [spq_pkg::HANDLE_W-1:0]     in_handle,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             ok,
  input wire logic [spq_pkg::IN_WEIGHT_W-1:0]  out_weight,
  input wire logic [spq_pkg::SYMBOL_W-1:0]     out_symbol,
  input wire logic [spq_pkg::HANDLE_W-1:0]     out_handle,
  input wire logic                             is_empty,
  input wire logic                             is_single,
  input wire logic [spq_pkg::OCC_W-1:0]        occupancy
);
  import spq_pkg::*;

  logic unused_in;
  logic [IN_WEIGHT_W+SYMBOL_W+HANDLE_W+OCC_W+2:0] out_word;

  assign unused_in = in_ready ^ kind ^ (^in_weight) ^ (^in_symbol) ^ (^in_handle) ^ in_valid;
  assign out_word  = {ok, out_weight, out_symbol, out_handle, is_empty, is_single, occupancy};

  // a stalled result word is held
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // failed operations return an all-zero entry
  `SPQ_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok, {out_weight, out_symbol, out_handle} == '0)

  // status flags agree with the count
  `SPQ_ASSERT_NOW(a_empty_flag, clk, rst, out_valid && is_empty, !is_single && (occupancy == '0))
  `SPQ_ASSERT_NOW(a_single_flag, clk, rst, out_valid && is_single, !is_empty && (occupancy == 9'd1))

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
